// ----- src/mvvp_pkg.sv -----
`default_nettype none
package mvvp_pkg;

  typedef enum logic [2:0] {
    REG_VIEW_X     = 3'd0,
    REG_VIEW_Y     = 3'd1,
    REG_VIEW_Z     = 3'd2,
    REG_VIEW_COS   = 3'd3,
    REG_VIEW_SIN   = 3'd4,
    REG_CENTER_X   = 3'd5,
    REG_CENTER_Y   = 3'd6,
    REG_PROJ_SCALE = 3'd7
  } mvvp_reg_e;

  typedef struct packed {
    logic signed [31:0] view_x;
    logic signed [31:0] view_y;
    logic signed [31:0] view_z;
    logic signed [17:0] view_cos;
    logic signed [17:0] view_sin;
    logic [11:0]        center_x;
    logic [11:0]        center_y;
    logic [30:0]        proj_scale;
  } mvvp_cfg_t;

  typedef struct packed {
    logic [7:0] ceiling_level;
    logic [7:0] floor_level;
    logic [6:0] corner_row;
    logic [6:0] corner_col;
  } mvvp_corner_t;

  typedef struct packed {
    logic signed [31:0] lateral;
    logic signed [31:0] depth;
    logic signed [31:0] floor_rel;
    logic signed [31:0] ceiling_rel;
    logic               projected;
  } mvvp_geom_t;

  typedef struct packed {
    mvvp_geom_t         geom;
    logic signed [15:0] screen_col;
    logic signed [15:0] floor_row;
    logic signed [15:0] ceiling_row;
  } mvvp_result_t;

  localparam logic [31:0] ScaleMax = 32'h7FFF_FFFF;

  function automatic logic signed [15:0] sat16(input logic signed [33:0] v);
    logic signed [15:0] r;
    if (v > 34'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -34'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- src/mvvp_xform.sv -----
`default_nettype none
module mvvp_xform #(
  parameter int FRAC_BITS  = 16,
  parameter int TILE_SHIFT = 6,
  parameter int NEAR_Z     = 16384
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  mvvp_pkg::mvvp_cfg_t    cfg_i,
  input  wire                    in_valid_i,
  output logic                   in_ready_o,
  input  mvvp_pkg::mvvp_corner_t in_i,
  output logic                   out_valid_o,
  input  wire                    out_ready_i,
  output mvvp_pkg::mvvp_geom_t   out_o
);
  import mvvp_pkg::*;

  localparam int TileSh = FRAC_BITS + TILE_SHIFT;

  // Stage A: offsets from the viewer.
  logic               va_q, rdy_a;
  logic signed [31:0] trx_q, try_q, frel_q, crel_q;
  logic signed [31:0] trx_d, try_d, frel_d, crel_d;
  // Stage B: the four rotation products.
  logic               vb_q, rdy_b;
  logic signed [31:0] p0_q, p1_q, p2_q, p3_q, fb_q, cb_q;
  logic signed [49:0] p0, p1, p2, p3;
  // Stage C: view space point.
  logic               vc_q, rdy_c;
  mvvp_geom_t         gc_d, gc_q;

  assign rdy_c = !vc_q || out_ready_i;
  assign rdy_b = !vb_q || rdy_c;
  assign rdy_a = !va_q || rdy_b;
  assign in_ready_o = rdy_a;

  always_comb begin
    trx_d  = ({25'b0, in_i.corner_col} << TileSh) - cfg_i.view_x;
    try_d  = ({25'b0, in_i.corner_row} << TileSh) - cfg_i.view_y;
    frel_d = ({24'b0, in_i.floor_level} << FRAC_BITS) - cfg_i.view_z;
    crel_d = ({24'b0, in_i.ceiling_level} << FRAC_BITS) - cfg_i.view_z;
  end

  assign p0 = try_q * cfg_i.view_cos;
  assign p1 = trx_q * cfg_i.view_sin;
  assign p2 = trx_q * cfg_i.view_cos;
  assign p3 = try_q * cfg_i.view_sin;

  always_comb begin
    gc_d.lateral     = p0_q + p1_q;
    gc_d.depth       = p2_q - p3_q;
    gc_d.floor_rel   = fb_q;
    gc_d.ceiling_rel = cb_q;
    gc_d.projected   = (gc_d.depth >= NEAR_Z);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (rdy_a) va_q <= in_valid_i;
      if (rdy_b) vb_q <= va_q;
      if (rdy_c) vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a && in_valid_i) begin
      trx_q  <= trx_d;
      try_q  <= try_d;
      frel_q <= frel_d;
      crel_q <= crel_d;
    end
    if (rdy_b && va_q) begin
      p0_q <= p0[FRAC_BITS+31:FRAC_BITS];
      p1_q <= p1[FRAC_BITS+31:FRAC_BITS];
      p2_q <= p2[FRAC_BITS+31:FRAC_BITS];
      p3_q <= p3[FRAC_BITS+31:FRAC_BITS];
      fb_q <= frel_q;
      cb_q <= crel_q;
    end
    if (rdy_c && vb_q) begin
      gc_q <= gc_d;
    end
  end

  assign out_valid_o = vc_q;
  assign out_o       = gc_q;
endmodule
`default_nettype wire

// ----- src/mvvp_div_cell.sv -----
`default_nettype none
module mvvp_div_cell #(
  parameter int DIV_W = 47
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  mvvp_pkg::mvvp_geom_t geom_i,
  input  wire [DIV_W-1:0]      dvd_i,
  input  wire [DIV_W-1:0]      quo_i,
  input  wire [31:0]           rem_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output mvvp_pkg::mvvp_geom_t geom_o,
  output logic [DIV_W-1:0]     dvd_o,
  output logic [DIV_W-1:0]     quo_o,
  output logic [31:0]          rem_o
);
  import mvvp_pkg::*;

  // One restoring division step: bring down the next dividend bit and
  // subtract the depth when it fits.
  logic        v_q;
  logic [31:0] rem2, rem_d;
  logic        qbit;

  assign in_ready_o = !v_q || out_ready_i;

  always_comb begin
    rem2  = {rem_i[30:0], dvd_i[DIV_W-1]};
    qbit  = (rem2 >= geom_i.depth);
    rem_d = qbit ? (rem2 - geom_i.depth) : rem2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (in_ready_o) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      geom_o <= geom_i;
      dvd_o  <= {dvd_i[DIV_W-2:0], 1'b0};
      quo_o  <= {quo_i[DIV_W-2:0], qbit};
      rem_o  <= rem_d;
    end
  end

  assign out_valid_o = v_q;
endmodule
`default_nettype wire

// ----- src/mvvp_screen.sv -----
`default_nettype none
module mvvp_screen #(
  parameter int FRAC_BITS = 16
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  mvvp_pkg::mvvp_cfg_t    cfg_i,
  input  wire                    in_valid_i,
  output logic                   in_ready_o,
  input  mvvp_pkg::mvvp_geom_t   geom_i,
  input  wire [31:0]             scale_i,
  output logic                   out_valid_o,
  input  wire                    out_ready_i,
  output mvvp_pkg::mvvp_result_t out_o
);
  import mvvp_pkg::*;

  logic               vd_q, ve_q, rdy_d, rdy_e;
  mvvp_geom_t         gd_q;
  logic signed [31:0] mx_q, mf_q, mc_q;
  logic signed [64:0] mx, mf, mc;
  logic signed [33:0] sx, sf, sc;
  mvvp_result_t       res_d, res_q;

  assign rdy_e = !ve_q || out_ready_i;
  assign rdy_d = !vd_q || rdy_e;
  assign in_ready_o = rdy_d;

  assign mx = geom_i.lateral * $signed({1'b0, scale_i});
  assign mf = geom_i.floor_rel * $signed({1'b0, scale_i});
  assign mc = geom_i.ceiling_rel * $signed({1'b0, scale_i});

  always_comb begin
    sx = $signed({22'b0, cfg_i.center_x}) + 34'(mx_q >>> FRAC_BITS);
    sf = $signed({22'b0, cfg_i.center_y}) - 34'(mf_q >>> FRAC_BITS);
    sc = $signed({22'b0, cfg_i.center_y}) - 34'(mc_q >>> FRAC_BITS);
    res_d.geom = gd_q;
    if (gd_q.projected) begin
      res_d.screen_col  = sat16(sx);
      res_d.floor_row   = sat16(sf);
      res_d.ceiling_row = sat16(sc);
    end else begin
      res_d.screen_col  = '0;
      res_d.floor_row   = '0;
      res_d.ceiling_row = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
      ve_q <= 1'b0;
    end else begin
      if (rdy_d) vd_q <= in_valid_i;
      if (rdy_e) ve_q <= vd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_d && in_valid_i) begin
      gd_q <= geom_i;
      mx_q <= mx[FRAC_BITS+31:FRAC_BITS];
      mf_q <= mf[FRAC_BITS+31:FRAC_BITS];
      mc_q <= mc[FRAC_BITS+31:FRAC_BITS];
    end
    if (rdy_e && vd_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = ve_q;
  assign out_o       = res_q;
endmodule
`default_nettype wire

// ----- src/map_vertex_view_project_core.sv -----
// Channel        | Direction | Handshake              | Payload
// s_axis         | in        | tvalid/tready          | tdata: col, row, floor, ceiling
// m_axis         | out       | tvalid/tready          | tdata: view point and screen, tuser
// APB config     | in        | psel/penable/pwrite    | eight view registers
//
// One corner is accepted per cycle when the output side keeps up.
// The pipe runs through the transform stages, a chain of division cells,
// one quotient bit per cell, and the screen stages; the chain sets its length.
// Every stage has its own valid bit, so bubbles close up under a stall.
// Reset clears all valid bits and loads the register defaults.
`default_nettype none
module map_vertex_view_project_core #(
  parameter int FRAC_BITS  = 16,
  parameter int TILE_SHIFT = 6,
  parameter int NEAR_Z     = 16384
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // [6:0] corner_col, [13:7] corner_row, [21:14] floor_level,
  // [29:22] ceiling_level, [31:30] zero
  input  wire  [31:0]  s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  wire          m_axis_tready_i,
  // [31:0] lateral, [63:32] depth, [95:64] floor_rel, [127:96] ceiling_rel,
  // [143:128] screen_col, [159:144] floor_row, [175:160] ceiling_row
  output logic [175:0] m_axis_tdata_o,
  // [0] projected
  output logic         m_axis_tuser_o,
  input  wire          psel_i,
  input  wire          penable_i,
  input  wire          pwrite_i,
  input  wire  [4:0]   paddr_i,
  input  wire  [31:0]  pwdata_i,
  output logic [31:0]  prdata_o,
  output logic         pready_o
);
  import mvvp_pkg::*;

  localparam int DivW = 31 + FRAC_BITS;

  mvvp_cfg_t    cfg_q;
  mvvp_reg_e    reg_sel;
  logic         wr_en;
  mvvp_corner_t corner;

  // Configuration registers. Writes land in the access phase.
  assign pready_o = 1'b1;
  assign reg_sel  = mvvp_reg_e'(paddr_i[4:2]);
  assign wr_en    = psel_i && penable_i && pwrite_i && pready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.view_x     <= '0;
      cfg_q.view_y     <= '0;
      cfg_q.view_z     <= '0;
      cfg_q.view_cos   <= 18'sd65536;
      cfg_q.view_sin   <= '0;
      cfg_q.center_x   <= 12'd160;
      cfg_q.center_y   <= 12'd100;
      cfg_q.proj_scale <= 31'd10485760;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_VIEW_X:     cfg_q.view_x     <= pwdata_i;
        REG_VIEW_Y:     cfg_q.view_y     <= pwdata_i;
        REG_VIEW_Z:     cfg_q.view_z     <= pwdata_i;
        REG_VIEW_COS:   cfg_q.view_cos   <= pwdata_i[17:0];
        REG_VIEW_SIN:   cfg_q.view_sin   <= pwdata_i[17:0];
        REG_CENTER_X:   cfg_q.center_x   <= pwdata_i[11:0];
        REG_CENTER_Y:   cfg_q.center_y   <= pwdata_i[11:0];
        REG_PROJ_SCALE: cfg_q.proj_scale <= pwdata_i[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_VIEW_X:     prdata_o = cfg_q.view_x;
      REG_VIEW_Y:     prdata_o = cfg_q.view_y;
      REG_VIEW_Z:     prdata_o = cfg_q.view_z;
      REG_VIEW_COS:   prdata_o = 32'(cfg_q.view_cos);
      REG_VIEW_SIN:   prdata_o = 32'(cfg_q.view_sin);
      REG_CENTER_X:   prdata_o = {20'b0, cfg_q.center_x};
      REG_CENTER_Y:   prdata_o = {20'b0, cfg_q.center_y};
      REG_PROJ_SCALE: prdata_o = {1'b0, cfg_q.proj_scale};
      default:        prdata_o = '0;
    endcase
  end

  // Front end: viewer offset, rotation, near test.
  assign corner = mvvp_corner_t'(s_axis_tdata_i[29:0]);

  logic       xf_valid;
  mvvp_geom_t xf_geom;

  // Division chain: scale = (proj_scale << FRAC_BITS) / depth.
  logic             c_valid [DivW+1];
  logic             c_ready [DivW+1];
  mvvp_geom_t       c_geom  [DivW+1];
  logic [DivW-1:0]  c_dvd   [DivW+1];
  logic [DivW-1:0]  c_quo   [DivW+1];
  logic [31:0]      c_rem   [DivW+1];

  mvvp_xform #(
    .FRAC_BITS (FRAC_BITS),
    .TILE_SHIFT(TILE_SHIFT),
    .NEAR_Z    (NEAR_Z)
  ) u_xform (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_i       (corner),
    .out_valid_o(xf_valid),
    .out_ready_i(c_ready[0]),
    .out_o      (xf_geom)
  );

  assign c_valid[0] = xf_valid;
  assign c_geom[0]  = xf_geom;
  assign c_dvd[0]   = {cfg_q.proj_scale, FRAC_BITS'(0)};
  assign c_quo[0]   = '0;
  assign c_rem[0]   = '0;

  for (genvar k = 0; k < DivW; k++) begin : g_cell
    mvvp_div_cell #(.DIV_W(DivW)) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .in_valid_i (c_valid[k]),
      .in_ready_o (c_ready[k]),
      .geom_i     (c_geom[k]),
      .dvd_i      (c_dvd[k]),
      .quo_i      (c_quo[k]),
      .rem_i      (c_rem[k]),
      .out_valid_o(c_valid[k+1]),
      .out_ready_i(c_ready[k+1]),
      .geom_o     (c_geom[k+1]),
      .dvd_o      (c_dvd[k+1]),
      .quo_o      (c_quo[k+1]),
      .rem_o      (c_rem[k+1])
    );
  end

  // Quotients beyond 31 bits saturate.
  logic [31:0]  scale;
  mvvp_result_t res;

  assign scale = (|c_quo[DivW][DivW-1:31]) ? ScaleMax : {1'b0, c_quo[DivW][30:0]};

  mvvp_screen #(.FRAC_BITS(FRAC_BITS)) u_screen (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (c_valid[DivW]),
    .in_ready_o (c_ready[DivW]),
    .geom_i     (c_geom[DivW]),
    .scale_i    (scale),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .out_o      (res)
  );

  assign m_axis_tdata_o = {res.ceiling_row, res.floor_row, res.screen_col,
                           res.geom.ceiling_rel, res.geom.floor_rel,
                           res.geom.depth, res.geom.lateral};
  assign m_axis_tuser_o = res.geom.projected;

  // A result that is not projected carries zero screen fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o) |->
      (res.screen_col == 16'sd0 && res.floor_row == 16'sd0 && res.ceiling_row == 16'sd0))
    else $error("screen fields set on a corner behind the near plane");

  // The projected flag agrees with the depth it came from.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tuser_o == (res.geom.depth >= NEAR_Z)))
    else $error("projected flag does not match depth");

  // The input only stalls when a finished result is held at the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input stalled without output back pressure");

endmodule
`default_nettype wire

// ----- tb/map_vertex_view_project_core_test.sv -----
`timescale 1ns / 1ps
`default_nettype none
module map_vertex_view_project_core_test;
  import mvvp_pkg::*;

  localparam int FracBits  = 16;
  localparam int TileShift = 6;
  localparam int NearZ     = 16384;
  // Pipe depth: 3 + (31 + FRAC_BITS) + 2 stages.
  localparam int PipeDepth = 3 + 31 + FracBits + 2;
  localparam int IdleLimit = 20000;

  // Expected projection results for corners that the block has taken, in order.
  class projection_scoreboard;
    mvvp_cfg_t    view;
    mvvp_result_t pending[$];
    int           errors;
    int           checked;
    int           projected_seen;

    function new();
      view.view_x     = 0;
      view.view_y     = 0;
      view.view_z     = 0;
      view.view_cos   = 18'sd65536;
      view.view_sin   = 0;
      view.center_x   = 12'd160;
      view.center_y   = 12'd100;
      view.proj_scale = 31'd10485760;
      errors = 0;
      checked = 0;
      projected_seen = 0;
    endfunction

    // Fixed point product with a floor shift, then wrapped to 32 bits.
    function automatic logic signed [31:0] fix_mul(longint a, longint b);
      longint p;
      p = (a * b) >>> FracBits;
      return p[31:0];
    endfunction

    function automatic logic signed [15:0] clamp16(longint v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
    endfunction

    function void note_corner(mvvp_corner_t c);
      mvvp_result_t r;
      logic signed [31:0] off_x, off_y;
      longint scale, t;
      t = longint'(c.floor_level) * 65536 - longint'(view.view_z);
      r.geom.floor_rel = t[31:0];
      t = longint'(c.ceiling_level) * 65536 - longint'(view.view_z);
      r.geom.ceiling_rel = t[31:0];
      t = longint'(c.corner_col) * (64'sd1 << (FracBits + TileShift)) - longint'(view.view_x);
      off_x = t[31:0];
      t = longint'(c.corner_row) * (64'sd1 << (FracBits + TileShift)) - longint'(view.view_y);
      off_y = t[31:0];
      t = longint'(fix_mul(off_y, view.view_cos)) + longint'(fix_mul(off_x, view.view_sin));
      r.geom.lateral = t[31:0];
      t = longint'(fix_mul(off_x, view.view_cos)) - longint'(fix_mul(off_y, view.view_sin));
      r.geom.depth = t[31:0];
      r.geom.projected = 1'b0;
      r.screen_col = 0;
      r.floor_row = 0;
      r.ceiling_row = 0;
      if (r.geom.depth >= NearZ) begin
        scale = (longint'(view.proj_scale) << FracBits) / longint'(r.geom.depth);
        if (scale > 64'sd2147483647) scale = 64'sd2147483647;
        r.geom.projected = 1'b1;
        r.screen_col = clamp16(longint'(view.center_x)
                               + (longint'(fix_mul(r.geom.lateral, scale)) >>> FracBits));
        r.floor_row = clamp16(longint'(view.center_y)
                              - (longint'(fix_mul(r.geom.floor_rel, scale)) >>> FracBits));
        r.ceiling_row = clamp16(longint'(view.center_y)
                                - (longint'(fix_mul(r.geom.ceiling_rel, scale)) >>> FracBits));
      end
      pending.push_back(r);
    endfunction

    function void check_result(logic [175:0] data, logic proj);
      mvvp_result_t exp_r;
      checked++;
      if (pending.size() == 0) begin
        report_mismatch("result with no corner waiting", 0, 0);
        return;
      end
      exp_r = pending.pop_front();
      if (exp_r.geom.projected) projected_seen++;
      if (data[31:0] !== exp_r.geom.lateral)
        report_mismatch("lateral", data[31:0], exp_r.geom.lateral);
      if (data[63:32] !== exp_r.geom.depth)
        report_mismatch("depth", data[63:32], exp_r.geom.depth);
      if (data[95:64] !== exp_r.geom.floor_rel)
        report_mismatch("floor_rel", data[95:64], exp_r.geom.floor_rel);
      if (data[127:96] !== exp_r.geom.ceiling_rel)
        report_mismatch("ceiling_rel", data[127:96], exp_r.geom.ceiling_rel);
      if (proj !== exp_r.geom.projected)
        report_mismatch("projected", proj, exp_r.geom.projected);
      if (data[143:128] !== exp_r.screen_col)
        report_mismatch("screen_col", data[143:128], exp_r.screen_col);
      if (data[159:144] !== exp_r.floor_row)
        report_mismatch("floor_row", data[159:144], exp_r.floor_row);
      if (data[175:160] !== exp_r.ceiling_row)
        report_mismatch("ceiling_row", data[175:160], exp_r.ceiling_row);
    endfunction

    function void report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("MISMATCH %s: got %h expected %h (result %0d)", what, got, want, checked);
    endfunction
  endclass

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid_i;
  logic         s_axis_tready_o;
  logic [31:0]  s_axis_tdata_i;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i;
  logic [175:0] m_axis_tdata_o;
  logic         m_axis_tuser_o;
  logic         psel_i;
  logic         penable_i;
  logic         pwrite_i;
  logic [4:0]   paddr_i;
  logic [31:0]  pwdata_i;
  logic [31:0]  prdata_o;
  logic         pready_o;

  map_vertex_view_project_core dut (.*);

  projection_scoreboard board;
  int  idle_cycles;
  int  sent;
  bit  hold_off;       // Long receiver hold-off requested by the stimulus.
  bit  stall_mode;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // The receiver stalls on its own pattern. When hold_off is raised it stays
  // low for a long counted stretch so the pipe fills and stalls the input.
  initial begin
    int run;
    m_axis_tready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        m_axis_tready_i <= 1'b0;
        for (int i = 0; i < 3 * PipeDepth; i++) @(posedge clk_i);
        hold_off = 1'b0;
        m_axis_tready_i <= 1'b1;
      end else begin
        run = $urandom_range(0, 3);
        case (run)
          0: m_axis_tready_i <= 1'b1;
          1: m_axis_tready_i <= ($urandom_range(0, 3) != 0);
          default: m_axis_tready_i <= stall_mode ? 1'($urandom_range(0, 1)) : 1'b1;
        endcase
        if ($urandom_range(0, 63) == 0) stall_mode = ~stall_mode;
      end
    end
  end

  // Checking and the watchdog live on the clock edge, sampling settled values.
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni) begin
        if (m_axis_tvalid_o && m_axis_tready_i)
          board.check_result(m_axis_tdata_o, m_axis_tuser_o);
        if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
          idle_cycles = 0;
        else
          idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
          $display("watchdog: no transfer for %0d cycles", IdleLimit);
          $display("map_vertex_view_project_core_test failed");
          $finish;
        end
      end
    end
  end

  // One APB write: setup cycle, then access cycle (pready is always high).
  task automatic write_reg(mvvp_reg_e idx, logic [31:0] value);
    psel_i    <= 1'b1;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b1;
    paddr_i   <= 5'(idx) << 2;
    pwdata_i  <= value;
    @(posedge clk_i);
    penable_i <= 1'b1;
    @(posedge clk_i);
    while (!pready_o) @(posedge clk_i);
    psel_i    <= 1'b0;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b0;
    case (idx)
      REG_VIEW_X:     board.view.view_x = value;
      REG_VIEW_Y:     board.view.view_y = value;
      REG_VIEW_Z:     board.view.view_z = value;
      REG_VIEW_COS:   board.view.view_cos = value[17:0];
      REG_VIEW_SIN:   board.view.view_sin = value[17:0];
      REG_CENTER_X:   board.view.center_x = value[11:0];
      REG_CENTER_Y:   board.view.center_y = value[11:0];
      REG_PROJ_SCALE: board.view.proj_scale = value[30:0];
      default: ;
    endcase
  endtask

  task automatic write_view(logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
                            logic [31:0] vcos, logic [31:0] vsin, logic [31:0] cx,
                            logic [31:0] cy, logic [31:0] ps);
    write_reg(REG_VIEW_X, vx);
    write_reg(REG_VIEW_Y, vy);
    write_reg(REG_VIEW_Z, vz);
    write_reg(REG_VIEW_COS, vcos);
    write_reg(REG_VIEW_SIN, vsin);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_PROJ_SCALE, ps);
  endtask

  // Offer one corner request and hold it until the block takes it. The valid
  // stays high between back-to-back requests; the caller lowers it on a gap.
  task automatic send_corner(logic [6:0] col, logic [6:0] row, logic [7:0] fl,
                             logic [7:0] cl);
    mvvp_corner_t c;
    c.corner_col = col;
    c.corner_row = row;
    c.floor_level = fl;
    c.ceiling_level = cl;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {2'b00, 30'(c)};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    board.note_corner(c);
    sent++;
  endtask

  task automatic pause_sender(int cycles);
    s_axis_tvalid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Wait until every expected result is in, then let the pipe run dry.
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (PipeDepth + 4) @(posedge clk_i);
  endtask

  // Mostly in-range corners near the viewer, with some fully random ones so
  // every input bit toggles, including indices above 64.
  task automatic random_phase(int count);
    int burst;
    for (int n = 0; n < count;) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && n < count; k++, n++) begin
        if ($urandom_range(0, 4) == 0)
          send_corner(7'($urandom), 7'($urandom), 8'($urandom), 8'($urandom));
        else
          send_corner(7'($urandom_range(0, 64)), 7'($urandom_range(0, 64)),
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 2) == 0) pause_sender($urandom_range(1, 12));
    end
  endtask

  initial begin
    board = new();
    sent = 0;
    hold_off = 1'b0;
    stall_mode = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    psel_i = 1'b0;
    penable_i = 1'b0;
    pwrite_i = 1'b0;
    paddr_i = '0;
    pwdata_i = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed corners at reset settings: the origin (depth zero, not
    // projected), field extremes, indices above 64, both level extremes.
    send_corner(0, 0, 0, 0);
    send_corner(64, 64, 255, 255);
    send_corner(127, 127, 255, 0);
    send_corner(1, 0, 0, 255);
    send_corner(0, 1, 128, 1);
    send_corner(64, 0, 0, 0);
    send_corner(1, 64, 255, 255);
    send_corner(127, 0, 1, 254);
    pause_sender(3);
    send_corner(2, 127, 85, 170);
    send_corner(1, 1, 1, 1);
    drain();

    // Huge scale with a tiny depth overflows the quotient and saturates the
    // screen values; the negative view_y extreme makes the row offsets wrap.
    write_view(32'h0000_0000 - 32'd16384, 32'h8000_0000, 32'h7FFF_FFFF,
               32'd65536, 32'd0, 32'd4095, 32'd4095, 32'h7FFF_FFFF);
    send_corner(0, 0, 0, 255);
    send_corner(1, 0, 255, 0);
    send_corner(0, 127, 0, 0);
    send_corner(127, 64, 255, 255);
    send_corner(1, 1, 0, 0);
    drain();

    // A rotated view, negative cos and positive sin of unit size, minimum scale.
    write_view(32'h7FFF_FFFF, 32'h0010_0000, 32'h8000_0000,
               32'h3_0000, 32'h1_0000, 32'd0, 32'd0, 32'd1);
    send_corner(0, 0, 255, 0);
    send_corner(64, 64, 0, 255);
    send_corner(127, 127, 17, 200);
    send_corner(32, 5, 3, 4);
    drain();

    // Random phases, each under its own view setting.
    for (int ph = 0; ph < 6; ph++) begin
      write_view($urandom_range(0, 64) << 22 | $urandom_range(0, 32'h3F_FFFF),
                 $urandom_range(0, 64) << 22 | $urandom_range(0, 32'h3F_FFFF),
                 $urandom_range(0, 255) << 16 | $urandom_range(0, 65535),
                 (ph == 5) ? 32'h3_0000 : 32'($signed($urandom_range(0, 131072)) - 65536),
                 (ph == 4) ? 32'd65536 : 32'($signed($urandom_range(0, 131072)) - 65536),
                 $urandom_range(0, 4095), $urandom_range(0, 4095),
                 (ph == 0) ? 32'h7FFF_FFFF : $urandom_range(1, 32'h0400_0000));
      if (ph == 2) hold_off = 1'b1;
      random_phase(270);
      drain();
    end

    // Fully random register values to toggle every config bit.
    write_view($urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom | 32'd1);
    random_phase(60);
    drain();

    $display("Sent %0d corners under ten view settings; %0d results checked, %0d projected.",
             sent, board.checked, board.projected_seen);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("map_vertex_view_project_core_test passed");
    end else begin
      $display("map_vertex_view_project_core_test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
